FILE: design/ctrh_pkg.sv
// ----------------------------------------------------------------------------
// ctrh_pkg
// Shared types for the cascaded traffic rate history: probe triple and the
// beat that moves between neighboring level cells.
// ----------------------------------------------------------------------------
package ctrh_pkg;

    localparam int unsigned DATA_W = 64;

    typedef struct packed {
        logic [DATA_W-1:0] tx;
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] span;
    } probe_t;

    typedef struct packed {
        logic   valid;
        probe_t data;
    } link_t;

    typedef struct packed {
        logic rd_en;
        logic wrap;
    } cell_ctrl_t;

endpackage

FILE: design/ctrh_cell.sv
// ----------------------------------------------------------------------------
// ctrh_cell
// One history level: probe ring, running totals and write slot. A probe beat
// from the finer neighbor is stored and summed; on ring wrap the totals are
// handed to the coarser neighbor on the next cycle.
// ----------------------------------------------------------------------------
module ctrh_cell
    import ctrh_pkg::*;
#(
    parameter int SLOTS = 360,
    parameter bit TOP   = 1'b0,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  link_t             push_in,
    output link_t             carry_out,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    output probe_t            rd_data,
    output probe_t            sums,
    output logic [SLOT_W-1:0] slot,
    output logic              wrap
);

    localparam logic [SLOT_W-1:0] SLOT_INIT = SLOT_W'(1 % SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    probe_t            mem [SLOTS];
    probe_t            rd_raw_reg;
    logic              rd_hit_reg;
    probe_t            sums_reg;
    probe_t            sums_next;
    probe_t            sum_new;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              wrapped_reg;
    logic              full_reg;
    logic              carry_valid_reg;
    probe_t            carry_data_reg;
    logic              wrap_reg;
    logic              slot_last;
    logic              hit;

    assign slot_last   = (slot_reg == SLOT_LAST);
    assign sum_new.tx   = sums_reg.tx + push_in.data.tx;
    assign sum_new.rx   = sums_reg.rx + push_in.data.rx;
    assign sum_new.span = sums_reg.span + push_in.data.span;

    always_comb
    begin
        sums_next = sums_reg;
        slot_next = slot_reg;
        if (push_in.valid)
        begin
            sums_next = (slot_last && !TOP) ? '0 : sum_new;
            slot_next = slot_last ? '0 : slot_reg + SLOT_W'(1);
        end
    end

    // written-entry tracking in place of a clearing pass
    assign hit = full_reg || ((rd_slot != '0) && (wrapped_reg || (rd_slot < slot_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg        <= '0;
            slot_reg        <= SLOT_INIT;
            wrapped_reg     <= 1'b0;
            full_reg        <= 1'b0;
            carry_valid_reg <= 1'b0;
            wrap_reg        <= 1'b0;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            sums_reg        <= sums_next;
            slot_reg        <= slot_next;
            carry_valid_reg <= push_in.valid && slot_last && !TOP;
            wrap_reg        <= push_in.valid && slot_last;
            if (push_in.valid && slot_last)
            begin
                wrapped_reg <= 1'b1;
            end
            if (push_in.valid && (slot_reg == '0))
            begin
                full_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.valid)
        begin
            mem[slot_reg]  <= push_in.data;
            carry_data_reg <= sum_new;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_slot];
        end
    end

    assign carry_out.valid = carry_valid_reg;
    assign carry_out.data  = carry_data_reg;
    assign rd_data         = rd_hit_reg ? rd_raw_reg : '0;
    assign sums            = sums_reg;
    assign slot            = slot_reg;
    assign wrap            = wrap_reg;

endmodule

FILE: design/cascaded_traffic_rate_history.sv
// ----------------------------------------------------------------------------
// cascaded_traffic_rate_history
// Multi-resolution traffic history: byte and time deltas of each sample go
// into the finest ring, and full rings cascade their totals to coarser ones.
// ----------------------------------------------------------------------------
// A sample beat (req_type 0) forms the deltas, pushes them into level 0, and
// each wrapping level hands its totals to the next cell in the cycle after
// its push; the beat completes once no cascade is in flight. A read beat
// (req_type 1) is served by the registered read of the level's ring memory.
// After reset the block accepts beats at once; never-written ring entries
// read as zero through per-level fill tracking. A finished result waits in
// the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module cascaded_traffic_rate_history
    import ctrh_pkg::*;
#(
    parameter int SLOTS  = 360,
    parameter int LEVELS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] now_us,
    input  logic [63:0] tx_total,
    input  logic [63:0] rx_total,
    input  logic [1:0]  level_sel,
    input  logic [8:0]  slot_sel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] tx_bytes,
    output logic [63:0] rx_bytes,
    output logic [63:0] span_us,
    output logic [63:0] total_tx,
    output logic [63:0] total_rx,
    output logic [63:0] total_span_us,
    output logic [8:0]  slot_now,
    output logic [1:0]  rollover_levels
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [63:0]       prev_tx_reg;
    logic [63:0]       prev_rx_reg;
    logic [63:0]       prev_time_reg;
    probe_t            delta_reg;
    logic              is_read_reg;
    logic              lv_ok_reg;
    logic              slot_ok_reg;
    logic [LV_W-1:0]   lv_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [1:0]        rolls_reg;
    logic [1:0]        rolls_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              load_out;
    logic              busy;
    logic [31:0]       lv_ext;
    logic [31:0]       slot_ext;
    logic [31:0]       slot_now_ext;
    cell_ctrl_t        ctrl;

    link_t             links [LEVELS+1];
    probe_t            rd_data [LEVELS];
    probe_t            sums [LEVELS];
    logic [SLOT_W-1:0] slots [LEVELS];
    logic [LEVELS-1:0] wraps;

    probe_t            res_probe;
    probe_t            res_sums;
    logic [SLOT_W-1:0] res_slot;
    logic [1:0]        res_rolls;

    probe_t            out_probe_reg;
    probe_t            out_sums_reg;
    logic [8:0]        out_slot_reg;
    logic [1:0]        out_rolls_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign lv_ext   = 32'(level_sel);
    assign slot_ext = 32'(slot_sel);

    assign links[0].valid = (state_reg == ST_PUSH);
    assign links[0].data  = delta_reg;
    assign ctrl.rd_en     = (state_reg == ST_READ);
    assign ctrl.wrap      = |wraps;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++)
        begin : g_cell
            ctrh_cell #(
                .SLOTS (SLOTS),
                .TOP   (g == LEVELS - 1)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .push_in   (links[g]),
                .carry_out (links[g+1]),
                .rd_en     (ctrl.rd_en),
                .rd_slot   (rd_slot_reg),
                .rd_data   (rd_data[g]),
                .sums      (sums[g]),
                .slot      (slots[g]),
                .wrap      (wraps[g])
            );
        end
    endgenerate

    always_comb
    begin
        busy = 1'b0;
        for (int i = 1; i <= LEVELS; i++)
        begin
            busy = busy | links[i].valid;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rolls_next = rolls_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rolls_next = '0;
                    state_next = req_type ? ST_READ : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (ctrl.wrap)
                begin
                    rolls_next = rolls_reg + 2'd1;
                end
                if (!busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (is_read_reg)
        begin
            res_probe = (lv_ok_reg && slot_ok_reg) ? rd_data[lv_reg] : '0;
            res_sums  = lv_ok_reg ? sums[lv_reg] : '0;
            res_slot  = lv_ok_reg ? slots[lv_reg] : '0;
            res_rolls = '0;
        end
        else
        begin
            res_probe = delta_reg;
            res_sums  = sums[0];
            res_slot  = slots[0];
            res_rolls = rolls_reg;
        end
    end

    assign slot_now_ext = 32'(res_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rolls_reg     <= '0;
            out_valid_reg <= 1'b0;
            prev_tx_reg   <= '0;
            prev_rx_reg   <= '0;
            prev_time_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rolls_reg     <= rolls_next;
            out_valid_reg <= out_valid_next;
            if (accept && !req_type)
            begin
                prev_tx_reg   <= tx_total;
                prev_rx_reg   <= rx_total;
                prev_time_reg <= now_us;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_read_reg    <= req_type;
            delta_reg.tx   <= tx_total - prev_tx_reg;
            delta_reg.rx   <= rx_total - prev_rx_reg;
            delta_reg.span <= now_us - prev_time_reg;
            lv_ok_reg      <= (lv_ext < LEVELS);
            slot_ok_reg    <= (slot_ext < SLOTS);
            lv_reg         <= lv_ext[LV_W-1:0];
            rd_slot_reg    <= slot_ext[SLOT_W-1:0];
        end
        if (load_out)
        begin
            out_probe_reg <= res_probe;
            out_sums_reg  <= res_sums;
            out_slot_reg  <= slot_now_ext[8:0];
            out_rolls_reg <= res_rolls;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tx_bytes        = out_probe_reg.tx;
    assign rx_bytes        = out_probe_reg.rx;
    assign span_us         = out_probe_reg.span;
    assign total_tx        = out_sums_reg.tx;
    assign total_rx        = out_sums_reg.rx;
    assign total_span_us   = out_sums_reg.span;
    assign slot_now        = out_slot_reg;
    assign rollover_levels = out_rolls_reg;

endmodule

FILE: sim/ctrh_tb_pkg.sv
// ----------------------------------------------------------------------------
// ctrh_tb_pkg
// Request codes and history geometry shared by the traffic history testbench
// top and its scoreboard.
// ----------------------------------------------------------------------------
package ctrh_tb_pkg;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_READ   = 1'b1
    } req_kind_t;

    localparam int HIST_SLOTS  = 360;
    localparam int HIST_LEVELS = 3;

endpackage

FILE: sim/rate_history_checker.sv
// ----------------------------------------------------------------------------
// rate_history_checker
// Scoreboard for the cascaded traffic rate history: mirrors the probe rings,
// level totals and write slots, predicts one result beat per accepted input
// beat and compares every accepted result beat field by field.
// ----------------------------------------------------------------------------
module rate_history_checker
    import ctrh_pkg::*;
    import ctrh_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] now_us,
    input  logic [63:0] tx_total,
    input  logic [63:0] rx_total,
    input  logic [1:0]  level_sel,
    input  logic [8:0]  slot_sel,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] tx_bytes,
    input  logic [63:0] rx_bytes,
    input  logic [63:0] span_us,
    input  logic [63:0] total_tx,
    input  logic [63:0] total_rx,
    input  logic [63:0] total_span_us,
    input  logic [8:0]  slot_now,
    input  logic [1:0]  rollover_levels,
    output int          mismatch_count,
    output int          pending_results,
    output int          samples_seen,
    output int          reads_seen,
    output int          wraps_seen
);

    typedef struct packed {
        probe_t     probe;
        probe_t     totals;
        logic [8:0] slot;
        logic [1:0] rolls;
    } history_beat_t;

    probe_t        ring_mem [HIST_LEVELS*HIST_SLOTS];
    probe_t        level_sum [HIST_LEVELS];
    int unsigned   write_slot [HIST_LEVELS];
    logic [63:0]   last_tx;
    logic [63:0]   last_rx;
    logic [63:0]   last_time;
    history_beat_t history_q [$];
    history_beat_t want_beat;
    int            errs;
    int            n_samples;
    int            n_reads;
    int            n_wraps;
    int            idx;

    function automatic bit push_level(int lv, probe_t p);
        int at;
        at = lv * HIST_SLOTS + int'(write_slot[lv]);
        ring_mem[at] = p;
        level_sum[lv].tx   = level_sum[lv].tx + p.tx;
        level_sum[lv].rx   = level_sum[lv].rx + p.rx;
        level_sum[lv].span = level_sum[lv].span + p.span;
        write_slot[lv]++;
        if (write_slot[lv] >= HIST_SLOTS)
        begin
            write_slot[lv] = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic history_beat_t predict_history(logic rt, logic [63:0] t_us,
                                                      logic [63:0] tx_c, logic [63:0] rx_c,
                                                      logic [1:0] lv, logic [8:0] sl);
        history_beat_t r;
        probe_t        delta;
        probe_t        carry;
        int            rolls;
        int            k;
        bit            wrapped;
        r = '0;
        if (rt == REQ_SAMPLE)
        begin
            delta.tx   = tx_c - last_tx;
            delta.rx   = rx_c - last_rx;
            delta.span = t_us - last_time;
            last_tx    = tx_c;
            last_rx    = rx_c;
            last_time  = t_us;
            rolls = 0;
            if (push_level(0, delta))
            begin
                rolls = 1;
                // full ring hands its totals one level up
                for (k = 0; k + 1 < HIST_LEVELS; k++)
                begin
                    carry = level_sum[k];
                    wrapped = push_level(k + 1, carry);
                    level_sum[k] = '0;
                    if (!wrapped)
                        break;
                    rolls++;
                end
            end
            r.probe  = delta;
            r.totals = level_sum[0];
            r.slot   = 9'(write_slot[0]);
            r.rolls  = 2'(rolls);
        end
        else if (lv < HIST_LEVELS)
        begin
            r.totals = level_sum[lv];
            r.slot   = 9'(write_slot[lv]);
            if (sl < HIST_SLOTS)
                r.probe = ring_mem[int'(lv) * HIST_SLOTS + int'(sl)];
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx = 0; idx < HIST_LEVELS * HIST_SLOTS; idx++)
                ring_mem[idx] = '0;
            for (idx = 0; idx < HIST_LEVELS; idx++)
            begin
                level_sum[idx]  = '0;
                write_slot[idx] = 1 % HIST_SLOTS;
            end
            last_tx   = '0;
            last_rx   = '0;
            last_time = '0;
            history_q.delete();
            errs      = 0;
            n_samples = 0;
            n_reads   = 0;
            n_wraps   = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
            samples_seen    <= 0;
            reads_seen      <= 0;
            wraps_seen      <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (history_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    errs++;
                end
                else
                begin
                    want_beat = history_q.pop_front();
                    check_field("tx_bytes", want_beat.probe.tx, tx_bytes);
                    check_field("rx_bytes", want_beat.probe.rx, rx_bytes);
                    check_field("span_us", want_beat.probe.span, span_us);
                    check_field("total_tx", want_beat.totals.tx, total_tx);
                    check_field("total_rx", want_beat.totals.rx, total_rx);
                    check_field("total_span_us", want_beat.totals.span, total_span_us);
                    check_field("slot_now", 64'(want_beat.slot), 64'(slot_now));
                    check_field("rollover_levels", 64'(want_beat.rolls),
                                64'(rollover_levels));
                end
            end
            if (in_valid && in_ready)
            begin
                want_beat = predict_history(req_type, now_us, tx_total, rx_total,
                                            level_sel, slot_sel);
                history_q.push_back(want_beat);
                if (req_type == REQ_SAMPLE)
                    n_samples++;
                else
                    n_reads++;
                if (want_beat.rolls != 0)
                    n_wraps++;
            end
            mismatch_count  <= errs;
            pending_results <= history_q.size();
            samples_seen    <= n_samples;
            reads_seen      <= n_reads;
            wraps_seen      <= n_wraps;
        end
    end

endmodule

FILE: sim/cascaded_traffic_rate_history_tb.sv
// ----------------------------------------------------------------------------
// cascaded_traffic_rate_history_tb
// Drives sample and read beats into the traffic history with random idling
// on both channels; the scoreboard beside the block checks every result.
// ----------------------------------------------------------------------------
module cascaded_traffic_rate_history_tb;
    import ctrh_pkg::*;
    import ctrh_tb_pkg::*;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic        req_type        = REQ_SAMPLE;
    logic [63:0] now_us          = '0;
    logic [63:0] tx_total        = '0;
    logic [63:0] rx_total        = '0;
    logic [1:0]  level_sel       = '0;
    logic [8:0]  slot_sel        = '0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [63:0] tx_bytes;
    logic [63:0] rx_bytes;
    logic [63:0] span_us;
    logic [63:0] total_tx;
    logic [63:0] total_rx;
    logic [63:0] total_span_us;
    logic [8:0]  slot_now;
    logic [1:0]  rollover_levels;

    int          mismatches;
    int          pending;
    int          n_samples;
    int          n_reads;
    int          n_wraps;
    bit          no_idle = 1'b0;
    int          sent_samples;
    logic [63:0] tx_ctr;
    logic [63:0] rx_ctr;
    logic [63:0] clock_us;

    cascaded_traffic_rate_history uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .now_us          (now_us),
        .tx_total        (tx_total),
        .rx_total        (rx_total),
        .level_sel       (level_sel),
        .slot_sel        (slot_sel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_bytes        (tx_bytes),
        .rx_bytes        (rx_bytes),
        .span_us         (span_us),
        .total_tx        (total_tx),
        .total_rx        (total_rx),
        .total_span_us   (total_span_us),
        .slot_now        (slot_now),
        .rollover_levels (rollover_levels)
    );

    rate_history_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .now_us          (now_us),
        .tx_total        (tx_total),
        .rx_total        (rx_total),
        .level_sel       (level_sel),
        .slot_sel        (slot_sel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_bytes        (tx_bytes),
        .rx_bytes        (rx_bytes),
        .span_us         (span_us),
        .total_tx        (total_tx),
        .total_rx        (total_rx),
        .total_span_us   (total_span_us),
        .slot_now        (slot_now),
        .rollover_levels (rollover_levels),
        .mismatch_count  (mismatches),
        .pending_results (pending),
        .samples_seen    (n_samples),
        .reads_seen      (n_reads),
        .wraps_seen      (n_wraps)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input req_kind_t kind, input logic [63:0] t_us,
                             input logic [63:0] tx_c, input logic [63:0] rx_c,
                             input logic [1:0] lv, input logic [8:0] sl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        now_us    <= t_us;
        tx_total  <= tx_c;
        rx_total  <= rx_c;
        level_sel <= lv;
        slot_sel  <= sl;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_sample(input logic [63:0] t_us, input logic [63:0] tx_c,
                               input logic [63:0] rx_c);
        // level and slot fields carry noise on samples
        send_beat(REQ_SAMPLE, t_us, tx_c, rx_c, 2'($urandom), 9'($urandom));
        sent_samples++;
    endtask

    task automatic send_read(input logic [1:0] lv, input logic [8:0] sl);
        send_beat(REQ_READ, rand64(), rand64(), rand64(), lv, sl);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // result side: random stall before each result beat
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        int          i;
        int          pick;
        logic [1:0]  lv;
        logic [8:0]  sl;
        sent_samples = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats
        send_read(2'd0, 9'd0);
        send_read(2'd2, 9'd359);
        send_sample(64'd1000, '1, 64'd1);
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                    64'hAAAA_AAAA_AAAA_AAAA);
        send_sample(64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_5555_5555);
        send_read(2'd0, 9'd1);
        send_read(2'd0, 9'd2);
        send_read(2'd0, 9'd5);
        send_read(2'd0, 9'd359);
        send_read(2'd0, 9'd360);
        send_read(2'd0, 9'd511);
        send_read(2'd1, 9'd0);
        send_read(2'd1, 9'd511);
        send_read(2'd2, 9'd256);
        send_read(2'd3, 9'd0);
        send_read(2'd3, 9'd511);
        drain_results();

        clock_us = 64'h7FFF_FFFF_FFFF_FFFF;
        tx_ctr   = 64'hAAAA_AAAA_AAAA_AAAA;
        rx_ctr   = 64'h5555_5555_5555_5555;

        for (i = 0; i < 550; i++)
        begin
            if (i % 50 == 0)
                no_idle <= ($urandom_range(0, 3) == 0);
            if (i == 180 || i == 380)
                drain_results();
            if ($urandom_range(0, 99) < 80)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    clock_us = rand64();
                    tx_ctr   = rand64();
                    rx_ctr   = rand64();
                end
                else if (pick == 1)
                begin
                    // counters and clock stepping backwards
                    clock_us = clock_us - $urandom_range(1, 5000);
                    tx_ctr   = tx_ctr - $urandom_range(0, 100000);
                    rx_ctr   = rx_ctr - $urandom_range(0, 100000);
                end
                else
                begin
                    clock_us = clock_us + $urandom_range(1, 2_000_000);
                    tx_ctr   = tx_ctr + $urandom_range(0, 96000);
                    rx_ctr   = rx_ctr + $urandom_range(0, 96000);
                end
                send_sample(clock_us, tx_ctr, rx_ctr);
            end
            else
            begin
                lv = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                if ($urandom_range(0, 3) == 0)
                    sl = 9'($urandom_range(0, 511));
                else if (lv == 2'd0)
                    sl = 9'($urandom_range(0, (sent_samples < 359) ? sent_samples : 359));
                else
                    sl = 9'($urandom_range(0, 3));
                send_read(lv, sl);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d sample beats and %0d read beats, %0d with a ring wrap",
                 n_samples, n_reads, n_wraps);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/ctrh_pkg.sv
design/ctrh_cell.sv
design/cascaded_traffic_rate_history.sv
sim/ctrh_tb_pkg.sv
sim/rate_history_checker.sv
sim/cascaded_traffic_rate_history_tb.sv
